// ===== hw/rtl/acbd_pkg.sv =====
`default_nettype none
package acbd_pkg;

   localparam int unsigned BlockBytes = 16;
   localparam int unsigned RegWidth   = 64;
   localparam int unsigned CsrIdxW    = 2;
   localparam int unsigned RoundKeyCount = 44;

   localparam logic [CsrIdxW-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_IV_HIGH  = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_IV_LOW   = 2'd3;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
      logic        last_block;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
      logic [4:0]  valid_bytes;
      logic        pad_error;
      logic        end_of_message;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEXP,
      ST_LOAD,
      ST_ROUND,
      ST_FINISH,
      ST_OUT
   } state_type;

   // sequencer -> round unit controls
   typedef struct packed {
      logic load;
      logic round;
      logic last_round;
   } round_ctl_type;

   function automatic logic [7:0] sbox_f(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] inv_sbox_f(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime_f(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] rcon_f(input logic [3:0] r);
      logic [7:0] v;
      unique case (r)
         4'd1: v = 8'h01;
         4'd2: v = 8'h02;
         4'd3: v = 8'h04;
         4'd4: v = 8'h08;
         4'd5: v = 8'h10;
         4'd6: v = 8'h20;
         4'd7: v = 8'h40;
         4'd8: v = 8'h80;
         4'd9: v = 8'h1b;
         4'd10: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aes_cbc_block_decryptor.sv =====
// AES-128 CBC block decryptor.
// Input channel req_*: one 128-bit ciphertext block per beat plus a last
// flag. Output channel rsp_*: one plaintext block per input beat, with the
// PKCS#7 pad count of a last block turned into valid_bytes / pad_error.
// csr_*: write-only registers key_high, key_low, iv_high, iv_low, taken at
// the next message start (first block after reset or after a last block).
// Steps: a key-row read, a load with round key 10, ten rounds and a
// chaining xor, then the result beat is offered; one round unit is
// reused for all ten rounds and the round-key RAM gives one 128-bit row
// per cycle.
// A message's first block also runs the key expansion first, one schedule
// word per cycle, every fourth word through the S-box word step.
// Flow control: one block in flight; req_stall is high in every state but
// ST_IDLE, so from acceptance until the result beat is taken.
// A stalled rsp beat holds its payload and holds off the next block.
// Reset: synchronous, active high; clears the key, IV and chain registers
// to zero, sets message start, and empties the pipeline.
`default_nettype none
module aes_cbc_block_decryptor
   import acbd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_payload_type      req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  wire logic                 csr_write,
   input  wire logic [CsrIdxW-1:0]   csr_index,
   input  wire logic [RegWidth-1:0]  csr_data
);
   state_type     state_ff, state_in;
   logic [63:0]   key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic [127:0]  chain_ff, chain_in;
   logic          start_ff, start_in;
   logic [127:0]  cipher_ff;
   logic          last_ff;
   logic [5:0]    cnt_ff, cnt_in;
   logic [3:0]    rnd_ff, rnd_in;
   logic [127:0]  win_ff, win_in;      // last four schedule words
   rsp_payload_type out_ff, out_in;
   round_ctl_type ctl;
   logic          ram_we;
   logic [3:0]    ram_raddr;
   logic [127:0]  ram_rdata;
   logic [127:0]  state_q, plain;
   logic [31:0]   t, w3, nw;
   logic [7:0]    pad;
   logic          accept;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         iv_high_ff  <= '0;
         iv_low_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            CSR_IV_HIGH:  iv_high_ff  <= csr_data;
            CSR_IV_LOW:   iv_low_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // round keys are stored as 128-bit rows, one per round
   acbd_ram #(.Width(128), .Depth(RoundKeyCount / 4)) u_rk (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (rnd_ff),
      .wr_data (win_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   acbd_round u_round (
      .clock     (clock),
      .ctl       (ctl),
      .load_data (cipher_ff),
      .round_key (ram_rdata),
      .state_q   (state_q)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_payload = out_ff;

   // key schedule word step
   assign w3 = win_ff[31:0];
   assign t  = {sbox_f(w3[23:16]) ^ rcon_f(rnd_ff + 4'd1), sbox_f(w3[15:8]),
                sbox_f(w3[7:0]), sbox_f(w3[31:24])};
   assign plain = state_q ^ chain_ff;
   assign pad   = plain[7:0];

   always_comb begin
      state_in = state_ff;
      chain_in = chain_ff;
      start_in = start_ff;
      cnt_in   = cnt_ff;
      rnd_in   = rnd_ff;
      win_in   = win_ff;
      out_in   = out_ff;
      ctl      = '0;
      ram_we   = 1'b0;
      ram_raddr = 4'd10;
      nw       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (start_ff) begin
                  win_in   = {key_high_ff, key_low_ff};
                  chain_in = {iv_high_ff, iv_low_ff};
                  rnd_in   = 4'd0;
                  cnt_in   = 6'd0;
                  state_in = ST_KEXP;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_KEXP: begin
            // write current row when a full row is present, then add a word
            nw = win_ff[127:96] ^ ((cnt_ff[1:0] == 2'd0) ? t : w3);
            ram_we = (cnt_ff[1:0] == 2'd0);
            if (cnt_ff == 6'd40) begin
               state_in = ST_LOAD;
            end else begin
               win_in = {win_ff[95:0], nw};
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[1:0] == 2'd3) begin
                  rnd_in = rnd_ff + 4'd1;
               end
            end
         end
         ST_LOAD: begin
            // ram row 10 is read now; next cycle the unit loads with it
            rnd_in   = 4'd9;
            state_in = ST_ROUND;
            ram_raddr = 4'd10;
            ctl.load = 1'b0;
            cnt_in   = 6'd0;
         end
         ST_ROUND: begin
            ram_raddr = rnd_ff;
            if (cnt_ff == 6'd0) begin
               ctl.load = 1'b1;
               cnt_in   = 6'd1;
               ram_raddr = 4'd9;
            end else begin
               ctl.round      = 1'b1;
               ctl.last_round = (rnd_ff == 4'd0);
               ram_raddr = (rnd_ff == 4'd0) ? 4'd0 : rnd_ff - 4'd1;
               if (rnd_ff == 4'd0) begin
                  state_in = ST_FINISH;
               end else begin
                  rnd_in = rnd_ff - 4'd1;
               end
            end
         end
         ST_FINISH: begin
            out_in.plain_high     = plain[127:64];
            out_in.plain_low      = plain[63:0];
            out_in.end_of_message = last_ff;
            out_in.pad_error      = 1'b0;
            out_in.valid_bytes    = 5'(BlockBytes);
            if (last_ff) begin
               if (pad == 8'd0 || pad > 8'(BlockBytes)) begin
                  out_in.pad_error = 1'b1;
               end else begin
                  out_in.valid_bytes = 5'(BlockBytes) - pad[4:0];
               end
               start_in = 1'b1;
            end else begin
               chain_in = cipher_ff;
               start_in = 1'b0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b1;
         chain_ff <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rnd_ff <= rnd_in;
      win_ff <= win_in;
      out_ff <= out_in;
      if (accept) begin
         cipher_ff <= {req_payload.cipher_high, req_payload.cipher_low};
         last_ff   <= req_payload.last_block;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/acbd_ram.sv =====
`default_nettype none
module acbd_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 44
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/acbd_round.sv =====
`default_nettype none
// Shared inverse round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns.
module acbd_round
   import acbd_pkg::*;
(
   input  wire logic          clock,
   input  wire round_ctl_type ctl,
   input  wire logic [127:0]  load_data,
   input  wire logic [127:0]  round_key,
   output logic      [127:0]  state_q
);
   logic [127:0] state_ff, state_in;
   logic [7:0]   sb [16];
   logic [7:0]   ak [16];
   logic [7:0]   mx [16];
   logic [7:0]   a0, a1, a2, a3;
   logic [7:0]   x2 [4], x4 [4], x8 [4];

   always_comb begin
      // byte k sits at bits 127-8k
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sb[c*4+r] = inv_sbox_f(state_ff[127 - 8*(((c - r + 4) % 4)*4 + r) -: 8]);
         end
      end
      for (int k = 0; k < 16; k++) begin
         ak[k] = sb[k] ^ round_key[127 - 8*k -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            x2[j] = xtime_f(ak[c*4+j]);
            x4[j] = xtime_f(x2[j]);
            x8[j] = xtime_f(x4[j]);
         end
         // 9 = 8+1, 11 = 8+2+1, 13 = 8+4+1, 14 = 8+4+2
         a0 = x8[0] ^ x4[0] ^ x2[0];
         a1 = x8[1] ^ x2[1] ^ ak[c*4+1];
         a2 = x8[2] ^ x4[2] ^ ak[c*4+2];
         a3 = x8[3] ^ ak[c*4+3];
         mx[c*4]   = a0 ^ a1 ^ a2 ^ a3;
         mx[c*4+1] = (x8[0] ^ ak[c*4]) ^ (x8[1] ^ x4[1] ^ x2[1])
                   ^ (x8[2] ^ x2[2] ^ ak[c*4+2]) ^ (x8[3] ^ x4[3] ^ ak[c*4+3]);
         mx[c*4+2] = (x8[0] ^ x4[0] ^ ak[c*4]) ^ (x8[1] ^ ak[c*4+1])
                   ^ (x8[2] ^ x4[2] ^ x2[2]) ^ (x8[3] ^ x2[3] ^ ak[c*4+3]);
         mx[c*4+3] = (x8[0] ^ x2[0] ^ ak[c*4]) ^ (x8[1] ^ x4[1] ^ ak[c*4+1])
                   ^ (x8[2] ^ ak[c*4+2]) ^ (x8[3] ^ x4[3] ^ x2[3]);
      end
      state_in = state_ff;
      if (ctl.load) begin
         state_in = load_data ^ round_key;
      end else if (ctl.round) begin
         for (int k = 0; k < 16; k++) begin
            state_in[127 - 8*k -: 8] = ctl.last_round ? ak[k] : mx[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign state_q = state_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/acbd_checker.sv =====
`default_nettype none
module acbd_checker
   import acbd_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_payload
);
   // result beat holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed under stall");

   // no new input while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while result pending");

   // one block in flight: input closes after an accepted beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open after accept");

   // valid_bytes never above a block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.valid_bytes <= 5'(BlockBytes))
      else $error("valid_bytes out of range");

   // errors and short blocks only at message end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.end_of_message |->
         !rsp_payload.pad_error && rsp_payload.valid_bytes == 5'(BlockBytes))
      else $error("pad result on non-last block");
endmodule

bind aes_cbc_block_decryptor acbd_checker u_acbd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

// ===== tb/aes_cbc_block_decryptor_tb.sv =====
module aes_cbc_block_decryptor_tb;
   import acbd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_write = 1'b0;
   logic [CsrIdxW-1:0] csr_index = CSR_KEY_HIGH;
   logic [RegWidth-1:0] csr_data = '0;

   aes_cbc_block_decryptor DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // decryptor state of the predictor
   logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
   logic [63:0] chain_hi, chain_lo;
   logic        at_msg_start;
   logic [31:0] sched [44];
   logic [7:0]  inv_box [256];

   req_payload_type block_queue [$];
   rsp_payload_type plain_queue [$];
   int  error_count = 0;
   bit  quiet_mode = 1'b0;   // no idling in the final stretch
   int  send_gap = 0;
   int  recv_gap = 0;

   function automatic logic [7:0] fwd_box(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return r;
   endfunction

   function automatic void build_schedule();
      logic [31:0] t;
      logic [7:0]  rc;
      sched[0] = key_hi_q[63:32];
      sched[1] = key_hi_q[31:0];
      sched[2] = key_lo_q[63:32];
      sched[3] = key_lo_q[31:0];
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         t = sched[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {fwd_box(t[31:24]), fwd_box(t[23:16]), fwd_box(t[15:8]), fwd_box(t[7:0])};
            t ^= {rc, 24'h0};
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
         end
         sched[i] = sched[i-4] ^ t;
      end
   endfunction

   // state byte k = column k/4, row k%4; byte 0 at the top of the 128-bit word
   function automatic logic [127:0] mix_key(input logic [127:0] s, input int rnd);
      return s ^ {sched[rnd*4], sched[rnd*4+1], sched[rnd*4+2], sched[rnd*4+3]};
   endfunction

   function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
      logic [7:0] b [16];
      logic [127:0] o;
      for (int k = 0; k < 16; k++) b[k] = s[127-8*k -: 8];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            o[127-8*(c*4+r) -: 8] = inv_box[b[((c - r + 4) % 4)*4 + r]];
      return o;
   endfunction

   function automatic logic [127:0] unmix(input logic [127:0] s);
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127-32*c -: 8];
         a1 = s[119-32*c -: 8];
         a2 = s[111-32*c -: 8];
         a3 = s[103-32*c -: 8];
         o[127-32*c -: 8] = gf_mul(a0,14) ^ gf_mul(a1,11) ^ gf_mul(a2,13) ^ gf_mul(a3,9);
         o[119-32*c -: 8] = gf_mul(a0,9) ^ gf_mul(a1,14) ^ gf_mul(a2,11) ^ gf_mul(a3,13);
         o[111-32*c -: 8] = gf_mul(a0,13) ^ gf_mul(a1,9) ^ gf_mul(a2,14) ^ gf_mul(a3,11);
         o[103-32*c -: 8] = gf_mul(a0,11) ^ gf_mul(a1,13) ^ gf_mul(a2,9) ^ gf_mul(a3,14);
      end
      return o;
   endfunction

   // one ciphertext block through the CBC decryptor
   function automatic rsp_payload_type decrypt_block(input req_payload_type blk);
      logic [127:0] s;
      logic [7:0]   pad;
      rsp_payload_type p;
      if (at_msg_start) begin
         build_schedule();
         chain_hi = iv_hi_q;
         chain_lo = iv_lo_q;
      end
      s = mix_key({blk.cipher_high, blk.cipher_low}, 10);
      for (int rnd = 9; rnd >= 1; rnd--) s = unmix(mix_key(unshift_unsub(s), rnd));
      s = mix_key(unshift_unsub(s), 0) ^ {chain_hi, chain_lo};
      p.plain_high = s[127:64];
      p.plain_low = s[63:0];
      p.valid_bytes = 5'd16;
      p.pad_error = 1'b0;
      p.end_of_message = blk.last_block;
      if (blk.last_block) begin
         pad = s[7:0];
         if (pad == 0 || pad > 16) p.pad_error = 1'b1;
         else p.valid_bytes = 5'(16 - pad);
         at_msg_start = 1'b1;
      end else begin
         chain_hi = blk.cipher_high;
         chain_lo = blk.cipher_low;
         at_msg_start = 1'b0;
      end
      return p;
   endfunction

   // forward cipher, used only to build blocks with a chosen pad byte
   function automatic logic [127:0] encrypt_raw(input logic [127:0] pt);
      logic [127:0] s, t;
      logic [7:0] a0, a1, a2, a3;
      s = mix_key(pt, 0);
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               t[127-8*(c*4+r) -: 8] = fwd_box(s[127-8*(((c + r) % 4)*4 + r) -: 8]);
         s = t;
         if (rnd != 10)
            for (int c = 0; c < 4; c++) begin
               a0 = t[127-32*c -: 8];
               a1 = t[119-32*c -: 8];
               a2 = t[111-32*c -: 8];
               a3 = t[103-32*c -: 8];
               s[127-32*c -: 8] = gf_mul(a0,2) ^ gf_mul(a1,3) ^ a2 ^ a3;
               s[119-32*c -: 8] = a0 ^ gf_mul(a1,2) ^ gf_mul(a2,3) ^ a3;
               s[111-32*c -: 8] = a0 ^ a1 ^ gf_mul(a2,2) ^ gf_mul(a3,3);
               s[103-32*c -: 8] = gf_mul(a0,3) ^ a1 ^ a2 ^ gf_mul(a3,2);
            end
         s = mix_key(s, rnd);
      end
      return s;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (block_queue.size() > 0) begin
            req_payload <= block_queue.pop_front();
            req_valid <= 1'b1;
            if (!quiet_mode && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predictor runs on each accepted beat
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) plain_queue.push_back(decrypt_block(req_payload));
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (plain_queue.size() == 0) begin
            $error("unexpected result beat");
            error_count++;
         end else begin
            e = plain_queue.pop_front();
            if (rsp_payload.plain_high !== e.plain_high) begin
               $error("plain_high exp %h got %h", e.plain_high, rsp_payload.plain_high);
               error_count++;
            end
            if (rsp_payload.plain_low !== e.plain_low) begin
               $error("plain_low exp %h got %h", e.plain_low, rsp_payload.plain_low);
               error_count++;
            end
            if (rsp_payload.valid_bytes !== e.valid_bytes) begin
               $error("valid_bytes exp %0d got %0d", e.valid_bytes, rsp_payload.valid_bytes);
               error_count++;
            end
            if (rsp_payload.pad_error !== e.pad_error) begin
               $error("pad_error exp %b got %b", e.pad_error, rsp_payload.pad_error);
               error_count++;
            end
            if (rsp_payload.end_of_message !== e.end_of_message) begin
               $error("end_of_message exp %b got %b", e.end_of_message,
                      rsp_payload.end_of_message);
               error_count++;
            end
         end
      end
      if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
         recv_gap <= $urandom_range(0, 16);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_KEY_HIGH: key_hi_q = val;
         CSR_KEY_LOW:  key_lo_q = val;
         CSR_IV_HIGH:  iv_hi_q = val;
         default:      iv_lo_q = val;
      endcase
   endtask

   task automatic drain();
      while (block_queue.size() > 0 || req_valid || plain_queue.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic load_setting(input logic [63:0] kh, kl, vh, vl);
      write_reg(CSR_KEY_HIGH, kh);
      write_reg(CSR_KEY_LOW, kl);
      write_reg(CSR_IV_HIGH, vh);
      write_reg(CSR_IV_LOW, vl);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // queue a random message; the last block gets a chosen pad byte when aim is set
   task automatic queue_message(input int blocks, input bit aim, input logic [7:0] pad);
      req_payload_type b;
      logic [127:0] prev, pt;
      prev = {iv_hi_q, iv_lo_q};
      for (int i = 0; i < blocks; i++) begin
         b.last_block = (i == blocks - 1);
         if (b.last_block && aim) begin
            build_schedule();
            pt = {rand64(), rand64()};
            pt[7:0] = pad;
            {b.cipher_high, b.cipher_low} = encrypt_raw(pt ^ prev);
         end else begin
            {b.cipher_high, b.cipher_low} = {rand64(), rand64()};
         end
         prev = {b.cipher_high, b.cipher_low};
         block_queue.push_back(b);
      end
   endtask

   initial begin
      logic [7:0] pads [6];
      req_payload_type b;
      int sent;
      pads = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd255};
      key_hi_q = 0; key_lo_q = 0; iv_hi_q = 0; iv_lo_q = 0;
      chain_hi = 0; chain_lo = 0; at_msg_start = 1'b1;
      foreach (sched[i]) sched[i] = 0;
      for (int i = 0; i < 256; i++) inv_box[fwd_box(8'(i))] = 8'(i);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset-zero key, extreme fields, pad byte edge values
      b = '{64'h0, 64'h0, 1'b1};
      block_queue.push_back(b);
      b = '{'1, '1, 1'b0};
      block_queue.push_back(b);
      b = '{'1, '1, 1'b1};
      block_queue.push_back(b);
      drain();
      load_setting('1, '1, '1, '1);
      foreach (pads[i]) queue_message(1 + i % 3, 1'b1, pads[i]);
      drain();
      load_setting(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
                   64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      queue_message(4, 1'b1, 8'd4);
      // let the message run down to its last two blocks, then drain
      while (block_queue.size() > 2) @(posedge clock);
      drain();
      sent = 0;

      // random phases with new settings
      for (int ph = 0; ph < 6; ph++) begin
         load_setting(rand64(), rand64(), rand64(), rand64());
         for (int m = 0; m < 28; m++) begin
            int n;
            n = $urandom_range(1, 6);
            queue_message(n, $urandom_range(0, 3) != 0, 8'($urandom_range(0, 20)));
            sent += n;
         end
         if (ph == 5) quiet_mode = 1'b1;
         drain();
      end
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
